### src/wba_pkg.sv
// Shared types and constants for the watermark backpressure admission block.
package wba_pkg;

   typedef enum logic [1:0] {
      OP_SEND    = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      POL_DROP   = 3'd0,
      POL_BUFFER = 3'd1,
      POL_BLOCK  = 3'd2,
      POL_FAIL   = 3'd3,
      POL_SIGNAL = 3'd4
   } policy_type;

   typedef enum logic [1:0] {
      ST_SUCCESS     = 2'd0,
      ST_DROPPED     = 2'd1,
      ST_BUFFER_FULL = 2'd2,
      ST_WOULD_BLOCK = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_STRATEGY   = 3'd0,
      REG_MAX_BYTES  = 3'd1,
      REG_MAX_MSGS   = 3'd2,
      REG_HIGH_BYTES = 3'd3,
      REG_HIGH_MSGS  = 3'd4,
      REG_LOW_BYTES  = 3'd5,
      REG_LOW_MSGS   = 3'd6
   } reg_idx_type;

   localparam int unsigned BYTES_W = 32;
   localparam int unsigned MSGS_W  = 16;
   localparam int unsigned SIZE_W  = 24;
   localparam int unsigned ADDR_W  = 5;

   localparam logic [2:0]         RST_STRATEGY   = 3'd0;
   localparam logic [BYTES_W-1:0] RST_MAX_BYTES  = 32'd1048576;
   localparam logic [MSGS_W-1:0]  RST_MAX_MSGS   = 16'd1024;
   localparam logic [BYTES_W-1:0] RST_HIGH_BYTES = 32'd786432;
   localparam logic [MSGS_W-1:0]  RST_HIGH_MSGS  = 16'd768;
   localparam logic [BYTES_W-1:0] RST_LOW_BYTES  = 32'd262144;
   localparam logic [MSGS_W-1:0]  RST_LOW_MSGS   = 16'd256;

   typedef struct packed {
      logic [BYTES_W-1:0] max_bytes;
      logic [MSGS_W-1:0]  max_msgs;
      logic [BYTES_W-1:0] high_bytes;
      logic [MSGS_W-1:0]  high_msgs;
      logic [BYTES_W-1:0] low_bytes;
      logic [MSGS_W-1:0]  low_msgs;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      policy_type        policy;
      logic [SIZE_W-1:0] msg_size;
   } item_type;

endpackage

### src/wba_csr.sv
// Configuration register file with an APB-style access port.
module wba_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [wba_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output logic [2:0]                  strategy,
   output wba_pkg::cfg_type            cfg
);
   import wba_pkg::*;

   logic [2:0]         strategy_ff, strategy_in;
   cfg_type            cfg_ff, cfg_in;
   reg_idx_type        idx;
   logic               wr_en;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[4:2]);
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      strategy_in = strategy_ff;
      cfg_in      = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_STRATEGY:   strategy_in        = pwdata[2:0];
            REG_MAX_BYTES:  cfg_in.max_bytes   = pwdata;
            REG_MAX_MSGS:   cfg_in.max_msgs    = pwdata[MSGS_W-1:0];
            REG_HIGH_BYTES: cfg_in.high_bytes  = pwdata;
            REG_HIGH_MSGS:  cfg_in.high_msgs   = pwdata[MSGS_W-1:0];
            REG_LOW_BYTES:  cfg_in.low_bytes   = pwdata;
            REG_LOW_MSGS:   cfg_in.low_msgs    = pwdata[MSGS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_STRATEGY:   prdata = {29'd0, strategy_ff};
         REG_MAX_BYTES:  prdata = cfg_ff.max_bytes;
         REG_MAX_MSGS:   prdata = {16'd0, cfg_ff.max_msgs};
         REG_HIGH_BYTES: prdata = cfg_ff.high_bytes;
         REG_HIGH_MSGS:  prdata = {16'd0, cfg_ff.high_msgs};
         REG_LOW_BYTES:  prdata = cfg_ff.low_bytes;
         REG_LOW_MSGS:   prdata = {16'd0, cfg_ff.low_msgs};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff       <= RST_STRATEGY;
         cfg_ff.max_bytes  <= RST_MAX_BYTES;
         cfg_ff.max_msgs   <= RST_MAX_MSGS;
         cfg_ff.high_bytes <= RST_HIGH_BYTES;
         cfg_ff.high_msgs  <= RST_HIGH_MSGS;
         cfg_ff.low_bytes  <= RST_LOW_BYTES;
         cfg_ff.low_msgs   <= RST_LOW_MSGS;
      end else begin
         strategy_ff <= strategy_in;
         cfg_ff      <= cfg_in;
      end
   end

   assign strategy = strategy_ff;
   assign cfg      = cfg_ff;

endmodule

### src/wba_front.sv
// Front end: decodes each request and resolves the overflow policy.
module wba_front (
   input  logic [1:0]                  req_func,
   input  logic [wba_pkg::SIZE_W-1:0]  req_msg_size,
   input  logic [2:0]                  strategy,
   output wba_pkg::item_type           item
);
   import wba_pkg::*;

   policy_type policy;

   // Undefined strategy codes behave like the buffer policy.
   always_comb begin
      unique case (policy_type'(strategy))
         POL_DROP:   policy = POL_DROP;
         POL_BUFFER: policy = POL_BUFFER;
         POL_BLOCK:  policy = POL_BLOCK;
         POL_FAIL:   policy = POL_FAIL;
         POL_SIGNAL: policy = POL_SIGNAL;
         default:    policy = POL_BUFFER;
      endcase
   end

   always_comb begin
      item.op       = op_type'(req_func);
      item.policy   = policy;
      item.msg_size = req_msg_size;
   end

endmodule

### src/wba_queue.sv
// Short FIFO that decouples the front end from the execution stage.
module wba_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wba_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output wba_pkg::item_type  head_item
);
   import wba_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("queue occupancy exceeds its depth");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("queue popped while empty");
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue pushed while full");

endmodule

### src/wba_back.sv
// Execution stage: pending counters, watermark flag and the result register.
module wba_back (
   input  logic                         clock,
   input  logic                         reset,
   input  wba_pkg::cfg_type             cfg,
   input  logic                         item_valid,
   input  wba_pkg::item_type            item,
   output logic                         item_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_can_send,
   output logic                         rsp_high_event,
   output logic                         rsp_low_event,
   output logic                         rsp_wake_waiters,
   output logic                         rsp_high_flag,
   output logic [wba_pkg::BYTES_W-1:0]  rsp_pending_bytes_out,
   output logic [wba_pkg::MSGS_W-1:0]   rsp_pending_msgs_out
);
   import wba_pkg::*;

   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [MSGS_W-1:0]  msgs_ff, msgs_in;
   logic               flag_ff, flag_in;

   logic               out_valid_ff, out_valid_in;
   status_type         status_ff, status_in;
   logic               can_ff, can_in;
   logic               hev_ff, hev_in;
   logic               lev_ff, lev_in;
   logic               wake_ff, wake_in;

   logic [BYTES_W:0]   sum_b;
   logic [MSGS_W:0]    msgs_p1;
   logic [BYTES_W-1:0] size_w;
   logic [BYTES_W-1:0] adm_bytes;
   logic [MSGS_W-1:0]  adm_msgs;
   logic               fits_max, fits_high, at_high, adm_high, adm_low;
   logic [BYTES_W-1:0] rel_bytes;
   logic [MSGS_W-1:0]  rel_msgs;
   logic               fire, admit;

   assign fire     = item_valid && (!out_valid_ff || !rsp_stall);
   assign item_pop = fire;

   assign size_w    = {{(BYTES_W-SIZE_W){1'b0}}, item.msg_size};
   assign sum_b     = {1'b0, bytes_ff} + {1'b0, size_w};
   assign msgs_p1   = {1'b0, msgs_ff} + {{MSGS_W{1'b0}}, 1'b1};
   assign fits_max  = (sum_b <= {1'b0, cfg.max_bytes}) && (msgs_p1 <= {1'b0, cfg.max_msgs});
   assign fits_high = (sum_b <= {1'b0, cfg.high_bytes}) && (msgs_p1 <= {1'b0, cfg.high_msgs});
   assign at_high   = (msgs_ff >= cfg.high_msgs) || (bytes_ff >= cfg.high_bytes);

   // Both counters saturate at their maximum on admission.
   assign adm_bytes = sum_b[BYTES_W] ? '1 : sum_b[BYTES_W-1:0];
   assign adm_msgs  = msgs_p1[MSGS_W] ? msgs_ff : msgs_p1[MSGS_W-1:0];
   assign adm_high  = (adm_msgs >= cfg.high_msgs) || (adm_bytes >= cfg.high_bytes);
   assign adm_low   = (adm_msgs <= cfg.low_msgs) && (adm_bytes <= cfg.low_bytes);

   assign rel_bytes = (bytes_ff >= size_w) ? bytes_ff - size_w : '0;
   assign rel_msgs  = (msgs_ff != '0) ? msgs_ff - 1'b1 : msgs_ff;

   always_comb begin
      bytes_in  = bytes_ff;
      msgs_in   = msgs_ff;
      flag_in   = flag_ff;
      status_in = status_ff;
      can_in    = can_ff;
      hev_in    = hev_ff;
      lev_in    = lev_ff;
      wake_in   = wake_ff;
      admit     = 1'b0;
      out_valid_in = fire || (out_valid_ff && rsp_stall);

      if (fire) begin
         status_in = ST_SUCCESS;
         can_in    = 1'b0;
         hev_in    = 1'b0;
         lev_in    = 1'b0;
         wake_in   = 1'b0;
         unique case (item.op)
            OP_SEND: begin
               if (fits_max) begin
                  admit = 1'b1;
               end else begin
                  unique case (item.policy)
                     POL_DROP: status_in = ST_DROPPED;
                     POL_FAIL: status_in = ST_BUFFER_FULL;
                     POL_SIGNAL: begin
                        status_in = ST_BUFFER_FULL;
                        flag_in   = 1'b1;
                        hev_in    = !flag_ff;
                     end
                     POL_BLOCK: begin
                        if (at_high) begin
                           status_in = ST_WOULD_BLOCK;
                        end else begin
                           admit = 1'b1;
                        end
                     end
                     default: admit = 1'b1;
                  endcase
               end
               if (admit) begin
                  bytes_in = adm_bytes;
                  msgs_in  = adm_msgs;
                  if (adm_high && !flag_ff) begin
                     flag_in = 1'b1;
                     hev_in  = 1'b1;
                  end else if (adm_low && flag_ff) begin
                     flag_in = 1'b0;
                     lev_in  = 1'b1;
                  end
               end
            end
            OP_RELEASE: begin
               bytes_in = rel_bytes;
               msgs_in  = rel_msgs;
               wake_in  = (bytes_ff >= cfg.high_bytes) && (rel_bytes <= cfg.low_bytes);
            end
            OP_QUERY: begin
               unique case (item.policy)
                  POL_DROP:   can_in = fits_max;
                  POL_FAIL:   can_in = fits_high;
                  POL_SIGNAL: can_in = fits_high;
                  default:    can_in = 1'b1;
               endcase
            end
            OP_CLEAR: begin
               bytes_in = '0;
               msgs_in  = '0;
               flag_in  = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff     <= '0;
         msgs_ff      <= '0;
         flag_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bytes_ff     <= bytes_in;
         msgs_ff      <= msgs_in;
         flag_ff      <= flag_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      can_ff    <= can_in;
      hev_ff    <= hev_in;
      lev_ff    <= lev_in;
      wake_ff   <= wake_in;
   end

   // The counters and flag reflect every transaction executed so far, including the one held in the result register.
   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_can_send          = can_ff;
   assign rsp_high_event        = hev_ff;
   assign rsp_low_event         = lev_ff;
   assign rsp_wake_waiters      = wake_ff;
   assign rsp_high_flag         = flag_ff;
   assign rsp_pending_bytes_out = bytes_ff;
   assign rsp_pending_msgs_out  = msgs_ff;

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (bytes_ff == '0 && msgs_ff == '0 && !flag_ff))
      else $error("state not cleared by reset");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_high_event |-> rsp_high_flag && !rsp_low_event)
      else $error("high event without the flag set");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_low_event |-> !rsp_high_flag)
      else $error("low event with the flag still set");

endmodule

### src/watermark_backpressure_admission.sv
// Path: an accepted transaction is queued, then executed into the result register.
// Throughput: one transaction per cycle while req_stall is low; the execution stage
// counter update is a combinational add and compare; a two-entry queue absorbs stalls.
// Reset: synchronous; clears pending counts, the watermark flag, the queue and the
// result valid, and loads every configuration register with its reset value.
module watermark_backpressure_admission #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_func,
   input  logic [wba_pkg::SIZE_W-1:0]   req_msg_size,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_can_send,
   output logic                         rsp_high_event,
   output logic                         rsp_low_event,
   output logic                         rsp_wake_waiters,
   output logic                         rsp_high_flag,
   output logic [wba_pkg::BYTES_W-1:0]  rsp_pending_bytes_out,
   output logic [wba_pkg::MSGS_W-1:0]   rsp_pending_msgs_out,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [wba_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import wba_pkg::*;

   logic [2:0] strategy;
   cfg_type    cfg;
   item_type   front_item;
   item_type   head_item;
   logic       q_full;
   logic       q_not_empty;
   logic       q_pop;
   logic       q_push;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   wba_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .strategy (strategy),
      .cfg      (cfg)
   );

   wba_front u_front (
      .req_func     (req_func),
      .req_msg_size (req_msg_size),
      .strategy     (strategy),
      .item         (front_item)
   );

   wba_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   wba_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .item_valid            (q_not_empty),
      .item                  (head_item),
      .item_pop              (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_can_send          (rsp_can_send),
      .rsp_high_event        (rsp_high_event),
      .rsp_low_event         (rsp_low_event),
      .rsp_wake_waiters      (rsp_wake_waiters),
      .rsp_high_flag         (rsp_high_flag),
      .rsp_pending_bytes_out (rsp_pending_bytes_out),
      .rsp_pending_msgs_out  (rsp_pending_msgs_out)
   );

endmodule
